// ----- src/assert_macros.svh -----
// Assertion macros shared by the checker files of this block.
// No dependencies; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, switched off while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds during reset.
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/atrld_pkg.sv -----
// Shared types and constants of the AT response line detector.
// No dependencies; imported by every module of the block.
`default_nettype none

package atrld_pkg;

  // Input function codes.
  localparam logic [2:0] FUNC_BYTE     = 3'd0;
  localparam logic [2:0] FUNC_TICK     = 3'd1;
  localparam logic [2:0] FUNC_LINE_ERR = 3'd2;
  localparam logic [2:0] FUNC_RING_OVF = 3'd3;
  localparam logic [2:0] FUNC_START    = 3'd4;

  // Result status codes.
  localparam logic [2:0] ST_PENDING      = 3'd0;
  localparam logic [2:0] ST_OK           = 3'd1;
  localparam logic [2:0] ST_ERROR_LINE   = 3'd2;
  localparam logic [2:0] ST_BUF_OVERFLOW = 3'd3;
  localparam logic [2:0] ST_RING_OVERFLOW = 3'd4;
  localparam logic [2:0] ST_LINE_ERROR   = 3'd5;
  localparam logic [2:0] ST_TIMEOUT      = 3'd6;

  // Configuration register indexes.
  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CAPACITY = 2'd1;
  localparam int CFG_DATA_W = 32;

  localparam logic [31:0] TIMEOUT_RESET  = 32'd5000;
  localparam logic [15:0] CAPACITY_RESET = 16'd512;

  // Characters the line tracker looks for.
  localparam logic [7:0] CH_O  = 8'h4F;
  localparam logic [7:0] CH_K  = 8'h4B;
  localparam logic [7:0] CH_E  = 8'h45;
  localparam logic [7:0] CH_R  = 8'h52;
  localparam logic [7:0] CH_NL = 8'h0A;

  // Both internal queues have this depth.
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    OP_BYTE,
    OP_TICK,
    OP_LINE_ERR,
    OP_RING_OVF,
    OP_START,
    OP_NONE
  } op_t;

  // A classified input beat.
  typedef struct packed {
    op_t        op;
    logic [7:0] data;
    logic       is_o;
    logic       is_e;
    logic       is_k;
    logic       is_r;
    logic       is_nl;
  } item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  stored_byte;
    logic [15:0] stored_length;
    logic [31:0] idle_elapsed;
  } result_t;

endpackage

`default_nettype wire

// ----- src/at_response_line_detector_unit.sv -----
// AT response line detector, top level. Depends on atrld_pkg, atrld_front
// and atrld_back. A beat is held in the front queue, then applied to the
// response state in the back end and written to the result queue, whose head
// drives the result ports. Throughput: one beat per cycle while the result
// queue has room. Reset (rst, synchronous) empties both queues,
// clears the response state and loads idle_limit = 5000, buffer_capacity = 512.
`default_nettype none

module at_response_line_detector_unit (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // Input queue side.
  input  wire logic                             push,
  output logic                                  full,
  input  wire logic [2:0]                       func,
  input  wire logic [7:0]                       rx_byte,
  // Result queue side.
  output logic                                  empty,
  input  wire logic                             pop,
  output logic [2:0]                            status,
  output logic [7:0]                            stored_byte,
  output logic [15:0]                           stored_length,
  output logic [31:0]                           idle_elapsed,
  // Configuration write port.
  input  wire logic                             cfg_write,
  input  wire logic [atrld_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [atrld_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import atrld_pkg::*;

  // The block is split in two halves joined by a short queue. The front
  // half takes an input beat whenever its queue has room, decodes the
  // function code and marks the characters the line tracker cares about.
  // The back half pulls one classified beat per cycle while its result queue has room,
  // applies it to the response state (timeout check, byte count, "OK"/"ERROR" prefix
  // tracking, completion status) and writes exactly one result beat into
  // its own result queue. Either side can stall without stopping the other
  // until a queue fills.

  logic [31:0] idle_limit;
  logic [15:0] buffer_capacity;
  logic        item_valid;
  item_t       item;
  logic        item_take;

  // Configuration registers. Writes to an index beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      idle_limit      <= TIMEOUT_RESET;
      buffer_capacity <= CAPACITY_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_TIMEOUT:  idle_limit      <= cfg_data[31:0];
        REG_CAPACITY: buffer_capacity <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  atrld_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .func       (func),
    .rx_byte    (rx_byte),
    .full       (full),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take)
  );

  atrld_back u_back (
    .clk             (clk),
    .rst             (rst),
    .idle_limit      (idle_limit),
    .buffer_capacity (buffer_capacity),
    .item_valid      (item_valid),
    .item            (item),
    .item_take       (item_take),
    .pop             (pop),
    .empty           (empty),
    .status          (status),
    .stored_byte     (stored_byte),
    .stored_length   (stored_length),
    .idle_elapsed    (idle_elapsed)
  );

endmodule

`default_nettype wire

// ----- src/atrld_front.sv -----
// Front end: accepts input beats, decodes the function code and flags the
// characters of interest, and queues the classified beats. Uses atrld_pkg.
`default_nettype none

module atrld_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire logic [2:0]      func,
  input  wire logic [7:0]      rx_byte,
  output logic                 full,
  output logic                 item_valid,
  output atrld_pkg::item_t     item,
  input  wire logic            item_take
);
  import atrld_pkg::*;

  item_t                  entries [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] head;
  logic [QUEUE_PTR_W-1:0] tail;
  logic [QUEUE_CNT_W-1:0] count;
  item_t                  classified;
  logic                   do_push;
  logic                   do_pop;

  always_comb begin
    classified.data  = rx_byte;
    classified.is_o  = (rx_byte == CH_O);
    classified.is_e  = (rx_byte == CH_E);
    classified.is_k  = (rx_byte == CH_K);
    classified.is_r  = (rx_byte == CH_R);
    classified.is_nl = (rx_byte == CH_NL);
    case (func)
      FUNC_BYTE:     classified.op = OP_BYTE;
      FUNC_TICK:     classified.op = OP_TICK;
      FUNC_LINE_ERR: classified.op = OP_LINE_ERR;
      FUNC_RING_OVF: classified.op = OP_RING_OVF;
      FUNC_START:    classified.op = OP_START;
      default:       classified.op = OP_NONE;
    endcase
  end

  assign full       = (count == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign item_valid = (count != '0);
  assign item       = entries[head];
  assign do_push    = push && !full;
  assign do_pop     = item_take && item_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[tail] <= classified;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        tail <= (tail == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail + 1'b1;
      end
      if (do_pop) begin
        head <= (head == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;
      end
      count <= count + QUEUE_CNT_W'(do_push) - QUEUE_CNT_W'(do_pop);
    end
  end

endmodule

`default_nettype wire

// ----- src/atrld_back.sv -----
// Back end: applies classified beats to the response state one per cycle
// while the result queue has room, and queues one result per beat. Uses atrld_pkg.
`default_nettype none

module atrld_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [31:0]      idle_limit,
  input  wire logic [15:0]      buffer_capacity,
  input  wire logic             item_valid,
  input  wire atrld_pkg::item_t item,
  output logic                  item_take,
  input  wire logic             pop,
  output logic                  empty,
  output logic [2:0]            status,
  output logic [7:0]            stored_byte,
  output logic [15:0]           stored_length,
  output logic [31:0]           idle_elapsed
);
  import atrld_pkg::*;

  typedef enum logic [2:0] {
    PFX_NONE,
    PFX_O,
    PFX_E,
    PFX_ER,
    PFX_ERR,
    PFX_ERRO
  } prefix_t;

  // Response state.
  logic [15:0] stored_count;
  logic [31:0] idle_ticks;
  logic        line_begin;
  prefix_t     prefix_progress;
  logic        error_line_seen;
  logic [2:0]  final_status;

  logic [15:0] stored_count_next;
  logic [31:0] idle_ticks_next;
  logic        line_begin_next;
  prefix_t     prefix_progress_next;
  logic        error_line_seen_next;
  logic [2:0]  final_status_next;
  logic [7:0]  stored_next;

  logic [15:0] room;
  logic [31:0] idle_inc;
  logic        ok_done;
  result_t     result_next;

  // Result queue.
  result_t                results [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] head;
  logic [QUEUE_PTR_W-1:0] tail;
  logic [QUEUE_CNT_W-1:0] count;
  logic                   out_pop;
  result_t                head_result;

  assign room     = (buffer_capacity >= 16'd2) ? buffer_capacity - 16'd1 : 16'd0;
  assign idle_inc = idle_ticks + 32'd1;

  always_comb begin
    stored_count_next    = stored_count;
    idle_ticks_next      = idle_ticks;
    line_begin_next      = line_begin;
    prefix_progress_next = prefix_progress;
    error_line_seen_next = error_line_seen;
    final_status_next    = final_status;
    stored_next          = 8'd0;
    ok_done              = 1'b0;

    if (item.op == OP_START) begin
      stored_count_next    = '0;
      idle_ticks_next      = '0;
      line_begin_next      = 1'b1;
      prefix_progress_next = PFX_NONE;
      error_line_seen_next = 1'b0;
      final_status_next    = (idle_limit == '0) ? ST_TIMEOUT : ST_PENDING;
    end else if (item.op != OP_NONE && final_status == ST_PENDING) begin
      if (idle_ticks >= idle_limit) begin
        final_status_next = ST_TIMEOUT;
      end else begin
        case (item.op)
          OP_LINE_ERR: final_status_next = ST_LINE_ERROR;
          OP_RING_OVF: final_status_next = ST_RING_OVERFLOW;
          OP_TICK: begin
            // Here idle_ticks is below the limit, so the sum cannot wrap
            // and reaching the limit means equality.
            idle_ticks_next = idle_inc;
            if (idle_inc == idle_limit) begin
              final_status_next = ST_TIMEOUT;
            end
          end
          OP_BYTE: begin
            if (stored_count >= room) begin
              final_status_next = ST_BUF_OVERFLOW;
            end else begin
              stored_count_next = stored_count + 16'd1;
              stored_next       = item.data;
              prefix_progress_next = PFX_NONE;
              if (line_begin) begin
                if (item.is_o) begin
                  prefix_progress_next = PFX_O;
                end else if (item.is_e) begin
                  prefix_progress_next = PFX_E;
                end
              end else begin
                case (prefix_progress)
                  PFX_O:    ok_done = item.is_k;
                  PFX_E:    if (item.is_r) prefix_progress_next = PFX_ER;
                  PFX_ER:   if (item.is_r) prefix_progress_next = PFX_ERR;
                  PFX_ERR:  if (item.is_o) prefix_progress_next = PFX_ERRO;
                  PFX_ERRO: if (item.is_r) error_line_seen_next = 1'b1;
                  default:  prefix_progress_next = PFX_NONE;
                endcase
              end
              line_begin_next = item.is_nl;
              // Success wins over an armed error line.
              if (ok_done) begin
                final_status_next = ST_OK;
              end else if (error_line_seen && item.is_nl) begin
                final_status_next = ST_ERROR_LINE;
              end
            end
          end
          default: ;
        endcase
      end
    end

    result_next.status        = final_status_next;
    result_next.stored_byte   = stored_next;
    result_next.stored_length = stored_count_next;
    result_next.idle_elapsed  = idle_ticks_next;
  end

  assign item_take   = item_valid && (count != QUEUE_CNT_W'(QUEUE_DEPTH));
  assign empty       = (count == '0);
  assign out_pop     = pop && !empty;
  assign head_result = results[head];

  assign status        = head_result.status;
  assign stored_byte   = head_result.stored_byte;
  assign stored_length = head_result.stored_length;
  assign idle_elapsed  = head_result.idle_elapsed;

  always_ff @(posedge clk) begin
    if (item_take) begin
      results[tail] <= result_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stored_count    <= '0;
      idle_ticks      <= '0;
      line_begin      <= 1'b1;
      prefix_progress <= PFX_NONE;
      error_line_seen <= 1'b0;
      final_status    <= ST_PENDING;
      head            <= '0;
      tail            <= '0;
      count           <= '0;
    end else begin
      if (item_take) begin
        stored_count    <= stored_count_next;
        idle_ticks      <= idle_ticks_next;
        line_begin      <= line_begin_next;
        prefix_progress <= prefix_progress_next;
        error_line_seen <= error_line_seen_next;
        final_status    <= final_status_next;
        tail <= (tail == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail + 1'b1;
      end
      if (out_pop) begin
        head <= (head == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;
      end
      count <= count + QUEUE_CNT_W'(item_take) - QUEUE_CNT_W'(out_pop);
    end
  end

endmodule

`default_nettype wire

// ----- src/atrld_checker.sv -----
// Port-level checker for the AT response line detector, bound to the top
// level. Depends on assert_macros.svh and atrld_pkg.
`default_nettype none

`include "assert_macros.svh"

module atrld_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        push,
  input wire logic        full,
  input wire logic        pop,
  input wire logic        empty,
  input wire logic [2:0]  status,
  input wire logic [7:0]  stored_byte,
  input wire logic [15:0] stored_length
);
  import atrld_pkg::*;

  // Both queues come out of reset empty.
  `ASSERT_NEXT_ALWAYS(a_reset_empty, clk, rst, empty && !full, "queues not empty after reset")

  // A waiting result that is not taken stays in place.
  `ASSERT_NEXT(a_result_held, clk, rst, !empty && !pop, !empty && $stable(status), "held result changed")

  // A stored byte other than zero means at least one byte is counted.
  `ASSERT_IMPLIES(a_length_counts, clk, rst, !empty && stored_byte != 8'd0, stored_length != 16'd0, "byte stored with zero length")

  // Only defined status codes leave the block.
  `ASSERT_IMPLIES(a_status_range, clk, rst, !empty, status <= ST_TIMEOUT, "undefined status code")

endmodule

bind at_response_line_detector_unit atrld_checker u_checker (
  .clk             (clk),
  .rst             (rst),
  .push            (push),
  .full            (full),
  .pop             (pop),
  .empty           (empty),
  .status          (status),
  .stored_byte     (stored_byte),
  .stored_length   (stored_length)
);

`default_nettype wire
